FILE: rtl/tgc_pkg.sv
package tgc_pkg;

  localparam int CoordW = 10;
  localparam int TimeW  = 32;
  localparam int ClampW = CoordW + 2;
  localparam int DiffW  = CoordW + 1;

  localparam int InDataW  = 56;
  localparam int OutDataW = 56;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [DiffW-1:0] AxisMargin = DiffW'(8);
  localparam logic [TimeW-1:0] TapMinMs   = TimeW'(12);

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CLICK = 3'd1,
    EV_LONG  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4
  } event_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE    = 3'd0,
    REG_ROTATION  = 3'd1,
    REG_SWIPE_MIN = 3'd2,
    REG_TAP_MOVE  = 3'd3,
    REG_LONG_MS   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  localparam logic signed [1:0] DirNeg  = 2'sb11;
  localparam logic signed [1:0] DirPos  = 2'sb01;
  localparam logic signed [1:0] DirNone = 2'sb00;

  typedef struct packed {
    logic [2:0]        touch_pad;
    logic [TimeW-1:0]  now_ms;
    logic [CoordW-1:0] raw_y;
    logic [CoordW-1:0] raw_x;
    logic              touch_present;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic               swiping;
    logic [CoordW-1:0]  live_y;
    logic [CoordW-1:0]  live_x;
    logic               live;
    logic signed [1:0]  swipe_dy;
    logic signed [1:0]  swipe_dx;
    logic               swipe_valid;
    logic [CoordW-1:0]  tap_y;
    logic [CoordW-1:0]  tap_x;
    logic               tap_valid;
    event_t             button_event;
  } result_t;

endpackage

FILE: rtl/touch_gesture_classifier_top.sv
// the result of each accepted poll is registered in the output register
// throughput: one poll per cycle while the output register is empty or its result is taken
// all gesture state updates at input acceptance, so back-to-back polls see it
// reset: rst_n synchronous active low; registers to defaults, gesture state
// cleared, output register empty
module touch_gesture_classifier_top
  import tgc_pkg::*;
#(
  parameter int SCREEN_W = 270,
  parameter int SCREEN_H = 584
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // touch_present, raw_x, raw_y, now_ms, zero pad
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // button_event, tap_valid, tap_x, tap_y, swipe_valid, swipe_dx, swipe_dy,
  // live, live_x, live_y, swiping, zero pad
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam logic signed [ClampW-1:0] XMax = ClampW'(SCREEN_W - 1);
  localparam logic signed [ClampW-1:0] YMax = ClampW'(SCREEN_H - 1);

  logic              enable_r;
  logic [1:0]        rotation_r;
  logic [CoordW-1:0] swipe_min_r;
  logic [CoordW-1:0] tap_move_r;
  logic [15:0]       long_ms_r;

  logic              finger_down_r, finger_down_nxt;
  logic [TimeW-1:0]  press_time_r, press_time_nxt;
  logic [CoordW-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [CoordW-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic              swipe_active_r, swipe_active_nxt;
  logic              live_flag_r, live_flag_nxt;

  logic              out_valid_r;
  result_t           out_data_r;
  result_t           res;
  in_item_t          item;
  logic              in_fire;

  logic signed [ClampW-1:0] sx_raw, sy_raw;
  logic [CoordW-1:0]  sx, sy, st_x_eff, st_y_eff;
  logic [DiffW-1:0]   mdx, mdy, rdx, rdy;
  logic [TimeW-1:0]   dur;
  logic [TimeW-1:0]   long_ms_ext;
  logic               sw_eff;

  function automatic logic [CoordW-1:0] clamp_c(input logic signed [ClampW-1:0] v,
                                                input logic signed [ClampW-1:0] hi);
    logic [CoordW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DiffW-1:0] adiff(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
    return (a >= b) ? DiffW'(a - b) : DiffW'(b - a);
  endfunction

  assign item      = in_item_t'(in_tdata);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(out_data_r);
  assign long_ms_ext = TimeW'(long_ms_r);

  // rotation and clamp
  always_comb begin
    unique case (rot_t'(rotation_r))
      ROT_90: begin
        sx_raw = YMax - $signed({2'b00, item.raw_y});
        sy_raw = $signed({2'b00, item.raw_x});
      end
      ROT_270: begin
        sx_raw = $signed({2'b00, item.raw_y});
        sy_raw = XMax - $signed({2'b00, item.raw_x});
      end
      default: begin
        sx_raw = $signed({2'b00, item.raw_x});
        sy_raw = $signed({2'b00, item.raw_y});
      end
    endcase
    sx = clamp_c(sx_raw, XMax);
    sy = clamp_c(sy_raw, YMax);
  end

  always_comb begin
    st_x_eff = finger_down_r ? start_x_r : sx;
    st_y_eff = finger_down_r ? start_y_r : sy;
    sw_eff   = finger_down_r && swipe_active_r;
    mdx      = adiff(sx, st_x_eff);
    mdy      = adiff(sy, st_y_eff);
    rdx      = adiff(last_x_r, start_x_r);
    rdy      = adiff(last_y_r, start_y_r);
    dur      = item.now_ms - press_time_r;
  end

  always_comb begin
    finger_down_nxt  = finger_down_r;
    press_time_nxt   = press_time_r;
    start_x_nxt      = start_x_r;
    start_y_nxt      = start_y_r;
    last_x_nxt       = last_x_r;
    last_y_nxt       = last_y_r;
    swipe_active_nxt = swipe_active_r;
    live_flag_nxt    = live_flag_r;
    res              = '0;
    res.button_event = EV_NONE;
    res.swipe_dx     = DirNone;
    res.swipe_dy     = DirNone;
    if (!enable_r) begin
      res.live    = live_flag_r;
      res.live_x  = live_flag_r ? last_x_r : '0;
      res.live_y  = live_flag_r ? last_y_r : '0;
      res.swiping = swipe_active_r;
    end else if (item.touch_present) begin
      live_flag_nxt = 1'b1;
      if (!finger_down_r) begin
        finger_down_nxt = 1'b1;
        press_time_nxt  = item.now_ms;
        start_x_nxt     = sx;
        start_y_nxt     = sy;
      end
      last_x_nxt = sx;
      last_y_nxt = sy;
      swipe_active_nxt = sw_eff ||
        ((mdx >= DiffW'(swipe_min_r)) && (mdx > mdy));
      res.live    = 1'b1;
      res.live_x  = sx;
      res.live_y  = sy;
      res.swiping = swipe_active_nxt;
    end else if (finger_down_r) begin
      finger_down_nxt  = 1'b0;
      live_flag_nxt    = 1'b0;
      swipe_active_nxt = 1'b0;
      if (rdx >= DiffW'(swipe_min_r) && rdx > rdy + AxisMargin) begin
        res.swipe_valid = 1'b1;
        if (last_x_r < start_x_r) begin
          res.swipe_dx     = DirNeg;
          res.button_event = EV_LEFT;
        end else begin
          res.swipe_dx     = DirPos;
          res.button_event = EV_RIGHT;
        end
      end else if (rdy >= DiffW'(swipe_min_r) && rdy > rdx + AxisMargin) begin
        res.swipe_valid = 1'b1;
        res.swipe_dy    = (last_y_r < start_y_r) ? DirNeg : DirPos;
      end else if (dur >= TapMinMs && dur < long_ms_ext &&
                   rdx <= DiffW'(tap_move_r) && rdy <= DiffW'(tap_move_r)) begin
        res.tap_valid    = 1'b1;
        res.tap_x        = last_x_r;
        res.tap_y        = last_y_r;
        res.button_event = EV_CLICK;
      end else if (dur >= long_ms_ext) begin
        res.button_event = EV_LONG;
      end
    end else begin
      live_flag_nxt = 1'b0;
      res.swiping   = swipe_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      rotation_r  <= 2'd0;
      swipe_min_r <= CoordW'(60);
      tap_move_r  <= CoordW'(24);
      long_ms_r   <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE:    enable_r    <= cfg_data[0];
        REG_ROTATION:  rotation_r  <= cfg_data[1:0];
        REG_SWIPE_MIN: swipe_min_r <= cfg_data[CoordW-1:0];
        REG_TAP_MOVE:  tap_move_r  <= cfg_data[CoordW-1:0];
        REG_LONG_MS:   long_ms_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_down_r  <= 1'b0;
      press_time_r   <= '0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      last_x_r       <= '0;
      last_y_r       <= '0;
      swipe_active_r <= 1'b0;
      live_flag_r    <= 1'b0;
    end else if (in_fire) begin
      finger_down_r  <= finger_down_nxt;
      press_time_r   <= press_time_nxt;
      start_x_r      <= start_x_nxt;
      start_y_r      <= start_y_nxt;
      last_x_r       <= last_x_nxt;
      last_y_r       <= last_y_nxt;
      swipe_active_r <= swipe_active_nxt;
      live_flag_r    <= live_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tgc_pkg::*;

  localparam int ScreenW    = 270;
  localparam int ScreenH    = 584;
  localparam int CycleLimit = 400000;
  localparam int StallLen   = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  touch_gesture_classifier_top #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // gesture tracker mirror: settings
  logic        en_r = 1'b0;
  rot_t        rot_r = ROT_0;
  int          swipe_thr = 60;
  int          tap_tol = 24;
  int          hold_ms = 1000;
  // gesture tracker mirror: touch state
  logic        finger_on = 1'b0;
  logic        swipe_on = 1'b0;
  logic        touch_shown = 1'b0;
  logic [31:0] press_ms = '0;
  int          org_x = 0;
  int          org_y = 0;
  int          cur_x = 0;
  int          cur_y = 0;

  result_t     gesture_q[$];
  int          fail_count = 0;
  int          polls_sent = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_left = 0;
  logic        stall_go = 1'b0;
  logic [31:0] clock_ms = '0;
  result_t     want_res;
  result_t     seen_res;

  function automatic result_t classify_poll(in_item_t p);
    result_t     r;
    int          sx;
    int          sy;
    int          adx;
    int          ady;
    logic [31:0] held;
    r = '0;
    r.button_event = EV_NONE;
    if (!en_r) begin
      r.live = touch_shown;
      if (touch_shown) begin
        r.live_x = CoordW'(cur_x);
        r.live_y = CoordW'(cur_y);
      end
      r.swiping = swipe_on;
    end else if (p.touch_present) begin
      case (rot_r)
        ROT_90: begin
          sx = ScreenH - 1 - int'(p.raw_y);
          sy = int'(p.raw_x);
        end
        ROT_270: begin
          sx = int'(p.raw_y);
          sy = ScreenW - 1 - int'(p.raw_x);
        end
        default: begin
          sx = int'(p.raw_x);
          sy = int'(p.raw_y);
        end
      endcase
      if (sx < 0) sx = 0;
      else if (sx > ScreenW - 1) sx = ScreenW - 1;
      if (sy < 0) sy = 0;
      else if (sy > ScreenH - 1) sy = ScreenH - 1;
      touch_shown = 1'b1;
      if (!finger_on) begin
        finger_on = 1'b1;
        press_ms = p.now_ms;
        org_x = sx;
        org_y = sy;
        swipe_on = 1'b0;
      end
      cur_x = sx;
      cur_y = sy;
      if (!swipe_on) begin
        adx = (cur_x >= org_x) ? cur_x - org_x : org_x - cur_x;
        ady = (cur_y >= org_y) ? cur_y - org_y : org_y - cur_y;
        if (adx >= swipe_thr && adx > ady) swipe_on = 1'b1;
      end
      r.live = 1'b1;
      r.live_x = CoordW'(cur_x);
      r.live_y = CoordW'(cur_y);
      r.swiping = swipe_on;
    end else if (finger_on) begin
      held = p.now_ms - press_ms;
      adx = (cur_x >= org_x) ? cur_x - org_x : org_x - cur_x;
      ady = (cur_y >= org_y) ? cur_y - org_y : org_y - cur_y;
      finger_on = 1'b0;
      touch_shown = 1'b0;
      swipe_on = 1'b0;
      if (adx >= swipe_thr && adx > ady + int'(AxisMargin)) begin
        r.swipe_valid = 1'b1;
        r.swipe_dx = (cur_x < org_x) ? DirNeg : DirPos;
        r.swipe_dy = DirNone;
        r.button_event = (cur_x < org_x) ? EV_LEFT : EV_RIGHT;
      end else if (ady >= swipe_thr && ady > adx + int'(AxisMargin)) begin
        r.swipe_valid = 1'b1;
        r.swipe_dx = DirNone;
        r.swipe_dy = (cur_y < org_y) ? DirNeg : DirPos;
      end else if (held >= TapMinMs && held < 32'(hold_ms) &&
                   adx <= tap_tol && ady <= tap_tol) begin
        r.tap_valid = 1'b1;
        r.tap_x = CoordW'(cur_x);
        r.tap_y = CoordW'(cur_y);
        r.button_event = EV_CLICK;
      end else if (held >= 32'(hold_ms)) begin
        r.button_event = EV_LONG;
      end
    end else begin
      touch_shown = 1'b0;
      r.swiping = swipe_on;
    end
    return r;
  endfunction

  function automatic int raw_clip(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = out_tdata;
      if (gesture_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: expected none actual %h", $time, out_tdata);
      end else begin
        want_res = gesture_q.pop_front();
        check_field("button_event", want_res.button_event, seen_res.button_event);
        check_field("tap_valid", want_res.tap_valid, seen_res.tap_valid);
        check_field("tap_x", want_res.tap_x, seen_res.tap_x);
        check_field("tap_y", want_res.tap_y, seen_res.tap_y);
        check_field("swipe_valid", want_res.swipe_valid, seen_res.swipe_valid);
        check_field("swipe_dx", want_res.swipe_dx, seen_res.swipe_dx);
        check_field("swipe_dy", want_res.swipe_dy, seen_res.swipe_dy);
        check_field("live", want_res.live, seen_res.live);
        check_field("live_x", want_res.live_x, seen_res.live_x);
        check_field("live_y", want_res.live_y, seen_res.live_y);
        check_field("swiping", want_res.swiping, seen_res.swiping);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_go) begin
      stall_left <= StallLen;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("touch_gesture_classifier_top verification failed");
    $finish;
  end

  task automatic send_poll(logic present, int x, int y, logic [31:0] t);
    in_item_t item;
    item = '0;
    item.touch_present = present;
    item.raw_x = CoordW'(x);
    item.raw_y = CoordW'(y);
    item.now_ms = t;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= item;
    do @(posedge clk); while (!in_tready);
    gesture_q.push_back(classify_poll(item));
    polls_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:    en_r = val[0];
      REG_ROTATION:  rot_r = rot_t'(val[1:0]);
      REG_SWIPE_MIN: swipe_thr = int'(val[9:0]);
      REG_TAP_MOVE:  tap_tol = int'(val[9:0]);
      REG_LONG_MS:   hold_ms = int'(val);
      default: ;
    endcase
  endtask

  task automatic configure(logic en, rot_t rot, int swipe, int tap, int hold);
    put_reg(REG_ENABLE, CfgDataW'(en));
    put_reg(REG_ROTATION, CfgDataW'(rot));
    put_reg(REG_SWIPE_MIN, CfgDataW'(swipe));
    put_reg(REG_TAP_MOVE, CfgDataW'(tap));
    put_reg(REG_LONG_MS, CfgDataW'(hold));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic play_gesture();
    int          moves;
    int          x0;
    int          y0;
    int          dx;
    int          dy;
    logic [31:0] t0;
    logic [31:0] span;
    // stray poll with random content
    if ($urandom_range(9) == 0) begin
      send_poll(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                $urandom);
      return;
    end
    if ($urandom_range(19) == 0) begin
      if ($urandom_range(1)) clock_ms = $urandom;
      else clock_ms = 32'hFFFF_FFFF - $urandom_range(2000);
    end
    if ($urandom_range(9) == 0) begin
      x0 = $urandom_range(1023);
      y0 = $urandom_range(1023);
    end else begin
      x0 = $urandom_range(600);
      y0 = $urandom_range(600);
    end
    case ($urandom_range(3))
      0: begin
        dx = $urandom_range(30);
        dy = $urandom_range(30);
      end
      1: begin
        dx = $urandom_range(400);
        dy = $urandom_range(40);
      end
      2: begin
        dx = $urandom_range(40);
        dy = $urandom_range(400);
      end
      default: begin
        dx = $urandom_range(1023);
        dy = $urandom_range(1023);
      end
    endcase
    if ($urandom_range(1)) dx = -dx;
    if ($urandom_range(1)) dy = -dy;
    case ($urandom_range(5))
      0: span = $urandom_range(11);
      1: span = (hold_ms > 12) ? $urandom_range(12, hold_ms - 1) : 32'd12;
      2: span = 32'(hold_ms) + $urandom_range(500);
      3: span = $urandom;
      4: begin
        case ($urandom_range(3))
          0: span = 32'd11;
          1: span = 32'd12;
          2: span = 32'(hold_ms) - 32'd1;
          default: span = 32'(hold_ms);
        endcase
      end
      default: span = $urandom_range(12, 300);
    endcase
    moves = $urandom_range(5);
    t0 = clock_ms + $urandom_range(1, 60);
    send_poll(1'b1, x0, y0, t0);
    for (int i = 1; i <= moves; i++) begin
      send_poll(1'b1,
                raw_clip(x0 + dx * i / moves + $urandom_range(6) - 3),
                raw_clip(y0 + dy * i / moves + $urandom_range(6) - 3),
                t0 + 32'(longint'(span) * i / (moves + 1)));
    end
    clock_ms = t0 + span;
    send_poll(1'b0, $urandom_range(1023), $urandom_range(1023), clock_ms);
    if ($urandom_range(7) == 0) begin
      clock_ms = clock_ms + $urandom_range(1, 20);
      send_poll(1'b0, $urandom_range(1023), $urandom_range(1023), clock_ms);
    end
  endtask

  task automatic test_disabled_after_reset();
    send_poll(1'b1, 1023, 1023, 32'hFFFF_FFFF);
    send_poll(1'b0, 0, 0, 32'h0000_0000);
    drain();
    configure(1'b1, ROT_0, 60, 24, 1000);
  endtask

  task automatic test_tap_across_wrap();
    send_poll(1'b1, 100, 200, 32'hFFFF_FFF8);
    send_poll(1'b1, 110, 212, 32'hFFFF_FFFF);
    send_poll(1'b0, 0, 0, 32'h0000_0010);
  endtask

  task automatic test_long_press();
    send_poll(1'b1, 0, 0, 32'd0);
    send_poll(1'b0, 1023, 1023, 32'd1500);
  endtask

  task automatic test_horizontal_swipes();
    send_poll(1'b1, 20, 300, 32'd2000);
    send_poll(1'b1, 150, 305, 32'd2100);
    send_poll(1'b0, 0, 0, 32'd2200);
    // start point clamped to the screen corner
    send_poll(1'b1, 1023, 1023, 32'd3000);
    send_poll(1'b1, 100, 583, 32'd3050);
    send_poll(1'b0, 0, 0, 32'd3100);
  endtask

  task automatic test_vertical_swipes();
    send_poll(1'b1, 100, 500, 32'd4000);
    send_poll(1'b1, 105, 100, 32'd4100);
    send_poll(1'b0, 0, 0, 32'd4200);
    send_poll(1'b1, 100, 0, 32'd5000);
    send_poll(1'b1, 100, 400, 32'd5100);
    send_poll(1'b0, 0, 0, 32'd5200);
  endtask

  task automatic test_unclassified_release();
    send_poll(1'b1, 50, 50, 32'd6000);
    send_poll(1'b0, 0, 0, 32'd6005);
    send_poll(1'b0, 0, 0, 32'd6010);
  endtask

  task automatic test_disabled_hold();
    send_poll(1'b1, 60, 60, 32'd7000);
    send_poll(1'b1, 200, 60, 32'd7100);
    drain();
    configure(1'b0, ROT_0, 60, 24, 1000);
    send_poll(1'b0, 0, 0, 32'd7200);
    send_poll(1'b1, 5, 5, 32'd7300);
    drain();
    configure(1'b1, ROT_0, 60, 24, 1000);
    send_poll(1'b0, 0, 0, 32'd7400);
  endtask

  task automatic test_random_polls(int setting, int n_polls);
    int target;
    drain();
    case (setting % 6)
      0: configure(1'b1, ROT_0, 60, 24, 1000);
      1: configure(1'b1, ROT_90, $urandom_range(20, 200), $urandom_range(5, 60),
                   $urandom_range(100, 3000));
      2: configure(1'b1, ROT_180, 0, 0, 0);
      3: configure(1'b1, ROT_270, 1023, 1023, 65535);
      4: configure(1'b1, rot_t'($urandom_range(3)), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(65535));
      default: configure(1'b1, ROT_0, 30, 10, 200);
    endcase
    target = polls_sent + n_polls;
    while (polls_sent < target) play_gesture();
  endtask

  task automatic test_output_stall();
    int target;
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(1'b1, ROT_0, 60, 24, 1000);
    stall_go <= 1'b1;
    @(posedge clk);
    stall_go <= 1'b0;
    target = polls_sent + 30;
    while (polls_sent < target) play_gesture();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 7;
    rx_idle_pct = 62;
    test_disabled_after_reset();
    test_tap_across_wrap();
    test_long_press();
    test_horizontal_swipes();
    test_vertical_swipes();
    test_unclassified_release();
    test_disabled_hold();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) test_random_polls(phase * 4 + s, 66);
    end

    test_output_stall();

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("touch_gesture_classifier_top verification clean");
    end else begin
      $display("touch_gesture_classifier_top verification failed");
    end
    $finish;
  end

endmodule
